// ===== rtl/lsbse_pkg.sv =====
// ----------------------------------------------------------------------------
// LSB stego extractor package
// Shared types, codes and defaults for the hidden-data extractor.
// ----------------------------------------------------------------------------
package lsbse_pkg;

   // Register defaults
   localparam logic [9:0] HEADER_BYTES_RESET = 10'd54;
   localparam logic [7:0] MAGIC_FIRST_RESET  = 8'd35;
   localparam logic [7:0] MAGIC_SECOND_RESET = 8'd42;
   localparam int         MAX_EXT_LEN_DEFAULT = 4;

   // Register indexes on the APB port (byte address = 4 * index)
   localparam logic [1:0] REG_HEADER_BYTES = 2'd0;
   localparam logic [1:0] REG_MAGIC_FIRST  = 2'd1;
   localparam logic [1:0] REG_MAGIC_SECOND = 2'd2;

   // Bit counts that close each gather
   localparam logic [4:0] LAST_BIT_BYTE  = 5'd7;
   localparam logic [4:0] LAST_BIT_MAGIC = 5'd15;
   localparam logic [4:0] LAST_BIT_WORD  = 5'd31;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_MAGIC    = 3'd1,
      PH_EXTLEN   = 3'd2,
      PH_EXTBYTES = 3'd3,
      PH_SECLEN   = 3'd4,
      PH_SECBYTES = 3'd5,
      PH_DONE     = 3'd6,
      PH_HALT     = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      KIND_EXT_BYTE  = 3'd0,
      KIND_SEC_BYTE  = 3'd1,
      KIND_EXT_LEN   = 3'd2,
      KIND_SEC_LEN   = 3'd3,
      KIND_MAGIC_ERR = 3'd4,
      KIND_EXT_LONG  = 3'd5
   } kind_type;

   typedef struct packed {
      logic [9:0] header_bytes;
      logic [7:0] magic_first;
      logic [7:0] magic_second;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [31:0] value;
      logic        last;
   } result_type;

endpackage

// ===== rtl/lsb_stego_extractor.sv =====
// ----------------------------------------------------------------------------
// LSB stego extractor
// Skips an image header, gathers hidden bits from byte LSBs and emits the
// decoded lengths, payload bytes and error results, tagged by kind.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  req     | in        | req_valid/req_ready  | req_image_byte[7:0]
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_kind[2:0] rsp_value[31:0]
//          |           |                      | rsp_last
//  csr     | in/out    | psel/penable/pready  | paddr[3:0] pwdata prdata
//
//  One image byte per clock; each byte is decoded in the cycle it is accepted
//  and any result appears in the result register on the next cycle.
//  req_ready drops only while a result waits in the result register and
//  rsp_ready is low.
//  Synchronous active-high reset restores the register defaults and the
//  header-skip phase; there is no clearing pass.
// ----------------------------------------------------------------------------
module lsb_stego_extractor #(
   parameter int MAX_EXT_LEN = lsbse_pkg::MAX_EXT_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_image_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_value,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import lsbse_pkg::*;

   cfg_type    cfg;
   result_type result;
   phase_type  phase;
   kind_type   kind;
   logic       req_xfer;
   logic       slot_free;

   assign req_ready = slot_free;
   assign req_xfer  = req_valid & req_ready;

   lsbse_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lsbse_core #(
      .MAX_EXT_LEN (MAX_EXT_LEN)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (req_xfer),
      .image_byte (req_image_byte),
      .cfg        (cfg),
      .result     (result),
      .phase      (phase)
   );

   lsbse_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .load      (req_xfer),
      .result    (result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_kind  (kind),
      .rsp_value (rsp_value),
      .rsp_last  (rsp_last),
      .slot_free (slot_free)
   );

   assign rsp_kind = kind;

   // Input stalls only behind a waiting, untaken result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without a blocked result");

   // A closing result leaves the core finished or halted
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && result.valid && result.last) |=> (phase == PH_DONE || phase == PH_HALT))
      else $error("closing result did not end the stream");

   // Error results always close the stream
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (kind == KIND_MAGIC_ERR || kind == KIND_EXT_LONG)) |-> rsp_last)
      else $error("error result without last");

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

// ===== rtl/lsbse_csr.sv =====
// ----------------------------------------------------------------------------
// LSB stego extractor register file
// APB-style configuration registers: header length and the two magic bytes.
// ----------------------------------------------------------------------------
module lsbse_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output lsbse_pkg::cfg_type cfg
);
   import lsbse_pkg::*;

   logic [9:0] header_bytes_ff;
   logic [7:0] magic_first_ff;
   logic [7:0] magic_second_ff;
   logic       wr_en;
   logic [1:0] reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign wr_en     = psel & penable & pwrite;

   // Write registers on the access phase of a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         header_bytes_ff <= HEADER_BYTES_RESET;
         magic_first_ff  <= MAGIC_FIRST_RESET;
         magic_second_ff <= MAGIC_SECOND_RESET;
      end else if (wr_en) begin
         case (reg_index)
            REG_HEADER_BYTES: header_bytes_ff <= pwdata[9:0];
            REG_MAGIC_FIRST:  magic_first_ff  <= pwdata[7:0];
            REG_MAGIC_SECOND: magic_second_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (reg_index)
         REG_HEADER_BYTES: prdata = {22'd0, header_bytes_ff};
         REG_MAGIC_FIRST:  prdata = {24'd0, magic_first_ff};
         REG_MAGIC_SECOND: prdata = {24'd0, magic_second_ff};
         default:          prdata = 32'd0;
      endcase
   end

   assign cfg.header_bytes = header_bytes_ff;
   assign cfg.magic_first  = magic_first_ff;
   assign cfg.magic_second = magic_second_ff;

endmodule

// ===== rtl/lsbse_core.sv =====
// ----------------------------------------------------------------------------
// LSB stego extractor decode core
// Per-byte phase sequencer: header skip, LSB gather, length and magic checks.
// ----------------------------------------------------------------------------
module lsbse_core #(
   parameter int MAX_EXT_LEN = lsbse_pkg::MAX_EXT_LEN_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             image_byte,
   input  lsbse_pkg::cfg_type     cfg,
   output lsbse_pkg::result_type  result,
   output lsbse_pkg::phase_type   phase
);
   import lsbse_pkg::*;

   localparam logic [30:0] EXT_LIMIT = 31'(MAX_EXT_LEN);

   phase_type   phase_ff,       phase_in;
   logic [9:0]  header_count_ff, header_count_in;
   logic [4:0]  bit_count_ff,   bit_count_in;
   logic [31:0] gather_ff,      gather_in;
   logic [30:0] items_left_ff,  items_left_in;

   phase_type   eff_phase;
   logic [4:0]  eff_bits;
   logic [30:0] len_n;
   logic [30:0] items_dec;
   logic        in_header;

   // Gather shifts in from the top, so the newest bit sits in bit 31
   assign gather_in = {image_byte[0], gather_ff[31:1]};
   assign len_n     = gather_in[31] ? 31'd0 : gather_in[30:0];
   assign items_dec = (items_left_ff != 31'd0) ? items_left_ff - 31'd1 : 31'd0;
   assign in_header = (phase_ff == PH_HEADER) && (header_count_ff < cfg.header_bytes);

   // Leaving the header falls straight into the magic gather on this byte
   assign eff_phase = (phase_ff == PH_HEADER) ? PH_MAGIC : phase_ff;
   assign eff_bits  = (phase_ff == PH_HEADER) ? 5'd0 : bit_count_ff;

   // Next state and result for one accepted byte
   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      bit_count_in    = eff_bits + 5'd1;
      items_left_in   = items_left_ff;
      result.valid    = 1'b0;
      result.kind     = KIND_EXT_BYTE;
      result.value    = 32'd0;
      result.last     = 1'b0;

      if (in_header) begin
         header_count_in = header_count_ff + 10'd1;
         bit_count_in    = bit_count_ff;
      end else begin
         case (eff_phase)
            PH_MAGIC: begin
               phase_in = PH_MAGIC;
               if (eff_bits == LAST_BIT_MAGIC) begin
                  bit_count_in = 5'd0;
                  if (gather_in[23:16] != cfg.magic_first ||
                      gather_in[31:24] != cfg.magic_second) begin
                     phase_in     = PH_HALT;
                     result.valid = 1'b1;
                     result.kind  = KIND_MAGIC_ERR;
                     result.value = {16'd0, gather_in[31:16]};
                     result.last  = 1'b1;
                  end else begin
                     phase_in = PH_EXTLEN;
                  end
               end
            end
            PH_EXTLEN: begin
               if (eff_bits == LAST_BIT_WORD) begin
                  bit_count_in = 5'd0;
                  result.valid = 1'b1;
                  result.value = gather_in;
                  if (len_n > EXT_LIMIT) begin
                     phase_in    = PH_HALT;
                     result.kind = KIND_EXT_LONG;
                     result.last = 1'b1;
                  end else begin
                     items_left_in = len_n;
                     phase_in      = (len_n == 31'd0) ? PH_SECLEN : PH_EXTBYTES;
                     result.kind   = KIND_EXT_LEN;
                  end
               end
            end
            PH_SECLEN: begin
               if (eff_bits == LAST_BIT_WORD) begin
                  bit_count_in  = 5'd0;
                  items_left_in = len_n;
                  phase_in      = (len_n == 31'd0) ? PH_DONE : PH_SECBYTES;
                  result.valid  = 1'b1;
                  result.kind   = KIND_SEC_LEN;
                  result.value  = gather_in;
                  result.last   = (len_n == 31'd0);
               end
            end
            PH_EXTBYTES, PH_SECBYTES: begin
               if (eff_bits == LAST_BIT_BYTE) begin
                  bit_count_in  = 5'd0;
                  items_left_in = items_dec;
                  result.valid  = 1'b1;
                  result.value  = {24'd0, gather_in[31:24]};
                  if (eff_phase == PH_EXTBYTES) begin
                     result.kind = KIND_EXT_BYTE;
                     if (items_dec == 31'd0) phase_in = PH_SECLEN;
                  end else begin
                     result.kind = KIND_SEC_BYTE;
                     result.last = (items_dec == 31'd0);
                     if (items_dec == 31'd0) phase_in = PH_DONE;
                  end
               end
            end
            default: begin
               // Done or halted: drop bytes until reset
               bit_count_in = bit_count_ff;
            end
         endcase
      end
   end

   // Advance state on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_count_ff <= 10'd0;
         bit_count_ff    <= 5'd0;
         gather_ff       <= 32'd0;
         items_left_ff   <= 31'd0;
      end else if (step) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         bit_count_ff    <= bit_count_in;
         gather_ff       <= gather_in;
         items_left_ff   <= items_left_in;
      end
   end

   assign phase = phase_ff;

endmodule

// ===== rtl/lsbse_outreg.sv =====
// ----------------------------------------------------------------------------
// LSB stego extractor result register
// Holds one result for the response channel and gives input-side ready.
// ----------------------------------------------------------------------------
module lsbse_outreg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  lsbse_pkg::result_type result,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output lsbse_pkg::kind_type   rsp_kind,
   output logic [31:0]           rsp_value,
   output logic                  rsp_last,
   output logic                  slot_free
);
   import lsbse_pkg::*;

   logic        valid_ff;
   kind_type    kind_ff;
   logic [31:0] value_ff;
   logic        last_ff;

   // Slot is free when empty or being drained this cycle
   assign slot_free = ~valid_ff | rsp_ready;

   // Hold valid until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load && result.valid) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Capture payload
   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         kind_ff  <= result.kind;
         value_ff <= result.value;
         last_ff  <= result.last;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind  = kind_ff;
   assign rsp_value = value_ff;
   assign rsp_last  = last_ff;

endmodule
